@@ rtl/edd16_pkg.sv @@
package edd16_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int PIX_W        = 8;
   localparam int LEVEL_W      = 4;
   localparam int ERR_W        = 11;
   localparam int VALUE_W      = 12;
   localparam int PROD_W       = 14;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd15;
   localparam logic signed [VALUE_W-1:0] VALUE_TOP = 12'sd240;
   localparam logic signed [PROD_W-1:0] ERR_LO = -14'sd1024;
   localparam logic signed [PROD_W-1:0] ERR_HI = 14'sd1023;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             last_col;
      logic             last_row;
      logic             first_col;
      logic             first_row;
   } pos_type;

   typedef struct packed {
      logic             valid;
      logic [COL_W-1:0] addr;
      logic [ERR_W-1:0] data;
   } wr_type;

   function automatic logic [COL_W:0] clamp_width(input logic [WIDTH_REG_W-1:0] v);
      logic [COL_W:0] r;
      if (v == '0) begin
         r = (COL_W+1)'(1);
      end else if (v > MAX_WIDTH) begin
         r = (COL_W+1)'(MAX_WIDTH);
      end else begin
         r = (COL_W+1)'(v);
      end
      return r;
   endfunction

   function automatic logic [ROW_W:0] clamp_height(input logic [HEIGHT_REG_W-1:0] v);
      logic [ROW_W:0] r;
      if (v == '0) begin
         r = (ROW_W+1)'(1);
      end else if (v > MAX_HEIGHT) begin
         r = (ROW_W+1)'(MAX_HEIGHT);
      end else begin
         r = (ROW_W+1)'(v);
      end
      return r;
   endfunction

   // divide by 16, truncating toward zero
   function automatic logic signed [PROD_W-1:0] div16(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] b;
      b = x + ((x < 0) ? 14'sd15 : 14'sd0);
      return b >>> 4;
   endfunction

   function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [PROD_W-1:0] x);
      logic signed [ERR_W-1:0] r;
      if (x < ERR_LO) begin
         r = ERR_W'(ERR_LO);
      end else if (x > ERR_HI) begin
         r = ERR_W'(ERR_HI);
      end else begin
         r = ERR_W'(x);
      end
      return r;
   endfunction

   localparam logic [COL_W:0] RESET_WIDTH  = clamp_width(11'd640);
   localparam logic [ROW_W:0] RESET_HEIGHT = clamp_height(13'd480);

endpackage

@@ rtl/edd16_ram.sv @@
module edd16_ram #(
   parameter int WIDTH  = 11,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/edd16_position.sv @@
module edd16_position (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            csr_write,
   input  edd16_pkg::csr_index_type        csr_index,
   input  logic [edd16_pkg::CSR_DATA_W-1:0] csr_data,
   output edd16_pkg::pos_type              pos,
   output logic                            clear_busy,
   output logic [edd16_pkg::COL_W-1:0]     clear_addr
);
   import edd16_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W:0]   width_ff;
   logic [ROW_W:0]   height_ff;
   logic             clear_ff, clear_in;
   logic [COL_W-1:0] clear_addr_ff, clear_addr_in;
   logic             last_col;
   logic             last_row;

   assign last_col = (({1'b0, col_ff}) + (COL_W+1)'(1)) >= width_ff;
   assign last_row = (({1'b0, row_ff}) + (ROW_W+1)'(1)) >= height_ff;

   assign pos.col       = col_ff;
   assign pos.last_col  = last_col;
   assign pos.last_row  = last_row;
   assign pos.first_col = (col_ff == '0);
   assign pos.first_row = (row_ff == '0);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // line buffer zero fill after reset
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + COL_W'(1);
         if (clear_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_ff <= clamp_width(csr_data[WIDTH_REG_W-1:0]);
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= clamp_height(csr_data[HEIGHT_REG_W-1:0]);
               end
               default: begin
                  width_ff <= width_ff;
               end
            endcase
         end
      end
   end

   assign clear_busy = clear_ff;
   assign clear_addr = clear_addr_ff;

endmodule

@@ rtl/edd16_diffuse.sv @@
module edd16_diffuse (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  edd16_pkg::pos_type              pos,
   input  logic [edd16_pkg::PIX_W-1:0]     pixel,
   input  logic [edd16_pkg::ERR_W-1:0]     rd_data,
   input  logic                            rsp_ready,
   output logic                            stage_free,
   output edd16_pkg::wr_type               ram_wr,
   output logic                            rsp_valid,
   output logic [edd16_pkg::PIX_W-1:0]     rsp_pixel,
   output logic                            rsp_frame_end
);
   import edd16_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]         s1_pix_ff;
   pos_type                  s1_pos_ff;
   logic                     byp_valid_ff, byp_valid_in;
   logic [ERR_W-1:0]         byp_data_ff, byp_data_in;
   logic signed [ERR_W-1:0]  rc_ff, rc_in;
   logic signed [ERR_W-1:0]  p0_ff, p0_in;
   logic signed [ERR_W-1:0]  p1_ff, p1_in;
   wr_type                   hold_ff, hold_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]         rsp_pixel_ff;
   logic                     rsp_frame_end_ff;

   logic                     advance;
   logic                     commit;
   logic signed [ERR_W-1:0]  above;
   logic signed [ERR_W-1:0]  carry;
   logic signed [ERR_W-1:0]  acc;
   logic signed [VALUE_W-1:0] value;
   logic [LEVEL_W-1:0]       level;
   logic signed [VALUE_W-1:0] err;
   logic signed [PROD_W-1:0] err_x;
   logic signed [PROD_W-1:0] share7, share5, share3, share1;
   logic signed [ERR_W-1:0]  below_left;
   logic signed [ERR_W-1:0]  p0_next;
   wr_type                   new_a, new_b;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign commit     = s1_valid_ff && advance;
   assign stage_free = !s1_valid_ff || advance;

   // quantise and split the error
   always_comb begin
      above  = s1_pos_ff.first_row ? '0 :
               (byp_valid_ff ? $signed(byp_data_ff) : $signed(rd_data));
      carry  = s1_pos_ff.first_col ? '0 : rc_ff;
      acc    = sat_err(PROD_W'(carry) + PROD_W'(above));
      value  = $signed({(VALUE_W-PIX_W)'(0), s1_pix_ff}) + VALUE_W'(acc);
      if (value < 0) begin
         level = '0;
      end else if (value >= VALUE_TOP) begin
         level = LEVEL_MAX;
      end else begin
         level = value[LEVEL_W+3:4];
      end
      err    = value - $signed({(VALUE_W-LEVEL_W-4)'(0), level, 4'b0000});
      err_x  = PROD_W'(err);
      share7 = div16(err_x * 14'sd7);
      share5 = div16(err_x * 14'sd5);
      share3 = div16(err_x * 14'sd3);
      share1 = div16(err_x);
      below_left = sat_err(PROD_W'(p0_ff) + share3);
      p0_next    = sat_err(PROD_W'(p1_ff) + share5);
   end

   always_comb begin
      rc_in = rc_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      new_a = '0;
      new_b = '0;
      if (commit) begin
         rc_in = s1_pos_ff.last_col ? '0 : sat_err(share7);
         if (!s1_pos_ff.last_row) begin
            new_a.valid = !s1_pos_ff.first_col;
            new_a.addr  = s1_pos_ff.col - COL_W'(1);
            new_a.data  = $unsigned(below_left);
            if (s1_pos_ff.last_col) begin
               new_b.valid = 1'b1;
               new_b.addr  = s1_pos_ff.col;
               new_b.data  = $unsigned(p0_next);
               p0_in       = '0;
               p1_in       = '0;
            end else begin
               p0_in = p0_next;
               p1_in = sat_err(share1);
            end
         end else begin
            p0_in = '0;
            p1_in = '0;
         end
      end
   end

   // one write port: an end-of-row pixel leaves its second write in the hold register
   always_comb begin
      if (hold_ff.valid) begin
         ram_wr  = hold_ff;
         hold_in = new_a.valid ? new_a : new_b;
      end else begin
         ram_wr  = new_a.valid ? new_a : new_b;
         hold_in = (new_a.valid && new_b.valid) ? new_b : '0;
      end
   end

   // forward writes that have not reached the line buffer yet
   always_comb begin
      byp_valid_in = byp_valid_ff;
      byp_data_in  = byp_data_ff;
      if (accept) begin
         priority if (hold_in.valid && (hold_in.addr == pos.col)) begin
            byp_valid_in = 1'b1;
            byp_data_in  = hold_in.data;
         end else if (ram_wr.valid && (ram_wr.addr == pos.col)) begin
            byp_valid_in = 1'b1;
            byp_data_in  = ram_wr.data;
         end else begin
            byp_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (commit) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= '0;
         byp_valid_ff <= 1'b0;
         rc_ff        <= '0;
         p0_ff        <= '0;
         p1_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         byp_valid_ff <= byp_valid_in;
         rc_ff        <= rc_in;
         p0_ff        <= p0_in;
         p1_ff        <= p1_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
      if (accept) begin
         s1_pix_ff <= pixel;
         s1_pos_ff <= pos;
      end
      if (commit) begin
         rsp_pixel_ff     <= {level, 4'b0000};
         rsp_frame_end_ff <= s1_pos_ff.last_col && s1_pos_ff.last_row;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

@@ rtl/error_diffusion_dither_16_level_core.sv @@
// each req passes the s1 register, then the result register held while rsp_ready is low
// throughput: one pixel per cycle unless stalled or filling; one line buffer read per pixel
// reset: counters, carried errors and output cleared; width 640, height 480
// after reset all MAX_WIDTH (1024) line buffer entries are zero filled with req_ready low
module error_diffusion_dither_16_level_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [edd16_pkg::PIX_W-1:0]      req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [edd16_pkg::PIX_W-1:0]      rsp_dithered_pixel,
   output logic                             rsp_frame_end,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  edd16_pkg::csr_index_type         csr_index,
   input  logic [edd16_pkg::CSR_DATA_W-1:0] csr_data
);
   import edd16_pkg::*;

   pos_type          pos;
   wr_type           ram_wr;
   logic             clear_busy;
   logic [COL_W-1:0] clear_addr;
   logic             stage_free;
   logic             accept;
   logic [ERR_W-1:0] rd_data;
   logic             mem_wr_en;
   logic [COL_W-1:0] mem_wr_addr;
   logic [ERR_W-1:0] mem_wr_data;

   assign csr_ready = 1'b1;
   assign req_ready = !clear_busy && stage_free;
   assign accept    = req_valid && req_ready;

   assign mem_wr_en   = clear_busy || ram_wr.valid;
   assign mem_wr_addr = clear_busy ? clear_addr : ram_wr.addr;
   assign mem_wr_data = clear_busy ? '0 : ram_wr.data;

   edd16_position u_position (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pos        (pos),
      .clear_busy (clear_busy),
      .clear_addr (clear_addr)
   );

   edd16_ram #(
      .WIDTH (ERR_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (rd_data)
   );

   edd16_diffuse u_diffuse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .pos           (pos),
      .pixel         (req_pixel_in),
      .rd_data       (rd_data),
      .rsp_ready     (rsp_ready),
      .stage_free    (stage_free),
      .ram_wr        (ram_wr),
      .rsp_valid     (rsp_valid),
      .rsp_pixel     (rsp_dithered_pixel),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

@@ rtl/edd16_checker.sv @@
module edd16_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_dithered_pixel,
   input logic       rsp_frame_end
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dithered_pixel)
         && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   // a fresh result follows an earlier req transfer
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching req transfer");

   // levels are multiples of sixteen
   a_rsp_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dithered_pixel[3:0] == 4'd0)
      else $error("dithered pixel off level grid");

   // line buffer fill blocks input straight after reset
   a_fill_block: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready)
      else $error("req accepted during line buffer fill");

endmodule

bind error_diffusion_dither_16_level_core edd16_checker u_checker (.*);
